// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the service mux framer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock edge, off while in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

// ===== rtl/ssmf_pkg.sv =====
// Shared types, constants and helper functions of the service mux framer.
// No dependencies.
package ssmf_pkg;

	localparam int MAX_PORTS = 8;
	localparam int PORT_W    = 3;
	localparam int CNT_W     = 4;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// Error codes carried on a result
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_NO_RESEND = 2'd1,
		ERR_BAD_ESC   = 2'd2,
		ERR_PORT      = 2'd3
	} err_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ESCAPE   = 3'd0,
		CFG_FORCE_ID = 3'd1,
		CFG_FIRST_ID = 3'd2,
		CFG_LAST_ID  = 3'd3,
		CFG_FLIP     = 3'd4,
		CFG_PORTS    = 3'd5
	} cfg_idx_t;

	localparam logic [7:0]       ESCAPE_RST   = 8'hC2;
	localparam logic [7:0]       FORCE_ID_RST = 8'hC1;
	localparam logic [7:0]       FIRST_ID_RST = 8'hD0;
	localparam logic [7:0]       LAST_ID_RST  = 8'hD7;
	localparam logic [7:0]       FLIP_RST     = 8'h20;
	localparam logic [CNT_W-1:0] PORTS_RST    = CNT_W'(8);

	typedef struct packed {
		logic [7:0]       escape_byte;
		logic [7:0]       force_id_byte;
		logic [7:0]       first_id_byte;
		logic [7:0]       last_id_byte;
		logic [7:0]       flip_mask;
		logic [CNT_W-1:0] ports_in_use;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic              target;
		logic [PORT_W-1:0] dest_port;
		logic [7:0]        out_byte;
		err_t              error;
	} res_t;

	// Work for the back end: one to three results of one input item
	typedef struct packed {
		logic [1:0]     cnt;
		res_t [2:0]     res;
	} act_t;

	function automatic logic is_id(input cfg_t cfg, input logic [7:0] c);
		return (c >= cfg.first_id_byte) && (c <= cfg.last_id_byte);
	endfunction

	function automatic logic is_special(input cfg_t cfg, input logic [7:0] c);
		return (c == cfg.escape_byte) || (c == cfg.force_id_byte) || is_id(cfg, c);
	endfunction

	function automatic res_t link_res(input logic [7:0] b);
		res_t r;
		r.target    = 1'b0;
		r.dest_port = '0;
		r.out_byte  = b;
		r.error     = ERR_NONE;
		return r;
	endfunction

	function automatic res_t err_res(input err_t e);
		res_t r;
		r.target    = 1'b0;
		r.dest_port = '0;
		r.out_byte  = '0;
		r.error     = e;
		return r;
	endfunction

endpackage

// ===== rtl/ssmf_front.sv =====
// Front end: accepts items, tracks link/service state, builds result groups.
// Depends on ssmf_pkg.
module ssmf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ssmf_pkg::cfg_t           cfg,
	input  logic                     push,
	input  logic                     full,
	input  logic                     kind,
	input  logic [ssmf_pkg::PORT_W-1:0] port,
	input  logic [7:0]               data,
	output logic                     enq,
	output ssmf_pkg::act_t           enq_act
);
	import ssmf_pkg::*;

	logic                 in_valid_q, out_valid_q, armed_q, ls_valid_q, ls_esc_q;
	logic [7:0]           in_svc_q, out_svc_q, ls_byte_q;
	logic                 in_valid_d, out_valid_d, armed_d, ls_valid_d, ls_esc_d;
	logic [7:0]           in_svc_d, out_svc_d, ls_byte_d;
	logic                 accept;
	logic [CNT_W-1:0]     port_lim;
	logic [7:0]           cc, idx, id, flip;
	act_t                 act;

	assign accept = push && !full;

	// Clamp the port count to the hardware limit
	assign port_lim = (cfg.ports_in_use > CNT_W'(MAX_PORTS)) ? CNT_W'(MAX_PORTS)
		: cfg.ports_in_use;

	// Classify the item, build its results and the next state
	always_comb begin
		in_valid_d  = in_valid_q;
		in_svc_d    = in_svc_q;
		out_valid_d = out_valid_q;
		out_svc_d   = out_svc_q;
		armed_d     = armed_q;
		ls_valid_d  = ls_valid_q;
		ls_esc_d    = ls_esc_q;
		ls_byte_d   = ls_byte_q;
		act.cnt     = 2'd0;
		act.res[0]  = link_res(8'h00);
		act.res[1]  = link_res(8'h00);
		act.res[2]  = link_res(8'h00);
		cc          = data;
		idx         = in_svc_q - cfg.first_id_byte;
		id          = cfg.first_id_byte + 8'(port);
		flip        = data ^ cfg.flip_mask;
		if (!kind) begin
			priority if (data == cfg.escape_byte) begin
				armed_d = 1'b1;
			end else if (is_id(cfg, data)) begin
				in_valid_d = 1'b1;
				in_svc_d   = data;
			end else if (data == cfg.force_id_byte) begin
				if (!ls_valid_q) begin
					act.cnt    = 2'd1;
					act.res[0] = err_res(ERR_NO_RESEND);
				end else begin
					act.res[0] = link_res(out_svc_q);
					if (ls_esc_q) begin
						act.cnt    = 2'd3;
						act.res[1] = link_res(cfg.escape_byte);
						act.res[2] = link_res(ls_byte_q);
					end else begin
						act.cnt    = 2'd2;
						act.res[1] = link_res(ls_byte_q);
					end
					ls_valid_d = 1'b0;
				end
			end else begin
				act.cnt = 2'd1;
				if (armed_q) begin
					cc      = flip;
					armed_d = 1'b0;
				end
				priority if (armed_q && !is_special(cfg, cc)) begin
					act.res[0] = err_res(ERR_BAD_ESC);
				end else if (!in_valid_q) begin
					act.res[0] = link_res(cfg.force_id_byte);
				end else if (idx >= 8'(port_lim)) begin
					act.res[0] = err_res(ERR_PORT);
				end else begin
					act.res[0].target    = 1'b1;
					act.res[0].dest_port = idx[PORT_W-1:0];
					act.res[0].out_byte  = cc;
					act.res[0].error     = ERR_NONE;
				end
			end
		end else if ({1'b0, port} >= port_lim) begin
			act.cnt    = 2'd1;
			act.res[0] = err_res(ERR_PORT);
		end else begin
			// Emit the service ID first when none was sent yet or it changed
			if (!out_valid_q || id != out_svc_q) begin
				act.res[0] = link_res(id);
				if (is_special(cfg, data)) begin
					act.cnt    = 2'd3;
					act.res[1] = link_res(cfg.escape_byte);
					act.res[2] = link_res(flip);
				end else begin
					act.cnt    = 2'd2;
					act.res[1] = link_res(data);
				end
			end else if (is_special(cfg, data)) begin
				act.cnt    = 2'd2;
				act.res[0] = link_res(cfg.escape_byte);
				act.res[1] = link_res(flip);
			end else begin
				act.cnt    = 2'd1;
				act.res[0] = link_res(data);
			end
			ls_esc_d    = is_special(cfg, data);
			ls_byte_d   = is_special(cfg, data) ? flip : data;
			ls_valid_d  = 1'b1;
			out_valid_d = 1'b1;
			out_svc_d   = id;
		end
	end

	assign enq     = accept && (act.cnt != 2'd0);
	assign enq_act = act;

	// Hold link state; advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			armed_q     <= 1'b0;
			ls_valid_q  <= 1'b0;
			ls_esc_q    <= 1'b0;
		end else if (accept) begin
			in_valid_q  <= in_valid_d;
			out_valid_q <= out_valid_d;
			armed_q     <= armed_d;
			ls_valid_q  <= ls_valid_d;
			ls_esc_q    <= ls_esc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_svc_q  <= in_svc_d;
			out_svc_q <= out_svc_d;
			ls_byte_q <= ls_byte_d;
		end
	end

endmodule

// ===== rtl/ssmf_queue.sv =====
// Short queue of result groups between the front and back ends.
// Depends on ssmf_pkg.
module ssmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enq,
	input  ssmf_pkg::act_t enq_act,
	input  logic           deq,
	output logic           full,
	output logic           head_valid,
	output ssmf_pkg::act_t head_act,
	output logic [ssmf_pkg::Q_CNT_W-1:0] count
);
	import ssmf_pkg::*;

	act_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_enq, do_deq;

	assign do_enq     = enq && (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign do_deq     = deq && (cnt_q != '0);
	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_act   = mem_q[rd_ptr_q];
	assign count      = cnt_q;

	function automatic logic [Q_PTR_W-1:0] nxt(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_enq) wr_ptr_q <= nxt(wr_ptr_q);
			if (do_deq) rd_ptr_q <= nxt(rd_ptr_q);
			if (do_enq && !do_deq) cnt_q <= cnt_q + 1'b1;
			else if (do_deq && !do_enq) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_enq) mem_q[wr_ptr_q] <= enq_act;
	end

endmodule

// ===== rtl/ssmf_back.sv =====
// Back end: steps a result group into the output register, one result per cycle
// while that register is empty or popped. Depends on ssmf_pkg.
module ssmf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  ssmf_pkg::act_t head_act,
	output logic           deq,
	input  logic           pop,
	output logic           empty,
	output ssmf_pkg::res_t res,
	output logic           last
);
	import ssmf_pkg::*;

	logic [1:0] idx_q;
	logic       ovalid_q;
	res_t       res_q;
	logic       last_q;
	logic       load, at_last;

	assign load    = head_valid && (!ovalid_q || pop);
	assign at_last = (idx_q == head_act.cnt - 2'd1);
	assign deq     = load && at_last;
	assign empty   = !ovalid_q;
	assign res     = res_q;
	assign last    = last_q;

	// Step the result index; free the group after its last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q    <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head_act.res[idx_q];
			last_q <= at_last;
		end
	end

endmodule

// ===== rtl/serial_service_mux_framer.sv =====
// Top level of the serial service mux framer: configuration registers and the
// front end, group queue and back end. Depends on ssmf_pkg and assert_macros.svh.
//
// Usage: an item is taken on every cycle that push is high and full is low; the
// front end classifies it in that cycle and files its one to three results as a
// group into a two-entry queue (items that give no result file nothing). The
// back end moves one result per cycle into the output register while that
// register is empty or popped, and the first result reaches the result ports
// through the queue entry and then the output register. Full rises only while
// both queue entries wait behind the output register.
`include "assert_macros.svh"

module serial_service_mux_framer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [2:0]               wr_index,
	input  logic [7:0]               wr_data,
	input  logic                     push,
	output logic                     full,
	input  logic                     kind,
	input  logic [ssmf_pkg::PORT_W-1:0] port,
	input  logic [7:0]               data,
	output logic                     empty,
	input  logic                     pop,
	output logic                     target,
	output logic [ssmf_pkg::PORT_W-1:0] dest_port,
	output logic [7:0]               out_byte,
	output logic [1:0]               error,
	output logic                     last
);
	import ssmf_pkg::*;

	cfg_t               cfg_q;
	logic               enq, deq, head_valid;
	act_t               enq_act, head_act;
	res_t               res;
	logic [Q_CNT_W-1:0] q_count;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_byte   <= ESCAPE_RST;
			cfg_q.force_id_byte <= FORCE_ID_RST;
			cfg_q.first_id_byte <= FIRST_ID_RST;
			cfg_q.last_id_byte  <= LAST_ID_RST;
			cfg_q.flip_mask     <= FLIP_RST;
			cfg_q.ports_in_use  <= PORTS_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_ESCAPE:   cfg_q.escape_byte   <= wr_data;
				CFG_FORCE_ID: cfg_q.force_id_byte <= wr_data;
				CFG_FIRST_ID: cfg_q.first_id_byte <= wr_data;
				CFG_LAST_ID:  cfg_q.last_id_byte  <= wr_data;
				CFG_FLIP:     cfg_q.flip_mask     <= wr_data;
				CFG_PORTS:    cfg_q.ports_in_use  <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	ssmf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.kind    (kind),
		.port    (port),
		.data    (data),
		.enq     (enq),
		.enq_act (enq_act)
	);

	ssmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.enq        (enq),
		.enq_act    (enq_act),
		.deq        (deq),
		.full       (full),
		.head_valid (head_valid),
		.head_act   (head_act),
		.count      (q_count)
	);

	ssmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_act   (head_act),
		.deq        (deq),
		.pop        (pop),
		.empty      (empty),
		.res        (res),
		.last       (last)
	);

	assign target    = res.target;
	assign dest_port = res.dest_port;
	assign out_byte  = res.out_byte;
	assign error     = res.error;

	// An error result stands alone and carries no byte
	`ASSERT_IMPLY(a_err_alone, clk, arst_n, !empty && (error != ERR_NONE),
		last && (out_byte == 8'h00) && !target, "error result not alone or carries a byte")
	// A byte routed to a local port never carries an error
	`ASSERT_IMPLY(a_port_clean, clk, arst_n, !empty && target,
		error == ERR_NONE, "local port result carries an error")
	// The queue never holds more groups than its depth
	`ASSERT_ALWAYS(a_q_bound, clk, arst_n, q_count <= Q_CNT_W'(Q_DEPTH),
		"group queue overfilled")
	// A group is only filed when the queue has room
	`ASSERT_IMPLY(a_no_enq_full, clk, arst_n, enq, !full, "group filed into full queue")

endmodule
